[rtl/odc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odc_pkg: shared types, constants and helpers of the occurrence dedup counter
// Item layouts, queue handshake structs, back-end states and byte masking.
// ----------------------------------------------------------------------------
package odc_pkg;

  // Entry capacity of one group and derived index width
  localparam int MAX_OCC = 64;
  localparam int IDX_W   = $clog2(MAX_OCC);

  // Field widths fixed by the item layout
  localparam int OCC_W   = 64;
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 7;
  localparam int GB_W    = 10;
  localparam int BYTES_N = OCC_W / 8;

  // Reset value of the byte-count register
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(BYTES_N);

  // Queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [OCC_W-1:0] value;
    logic             group_end;
  } occ_item_t;

  typedef struct packed {
    logic      push;
    occ_item_t item;
  } queue_push_t;

  typedef struct packed {
    logic      not_empty;
    occ_item_t head;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MATCH,
    B_UPDATE,
    B_EMIT
  } back_state_t;

  // Clamp the register to 1..8 bytes
  function automatic logic [CFG_W-1:0] eff_bytes(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] b;
    b = cfg;
    if (b == '0) begin
      b = CFG_W'(1);
    end
    if (b > CFG_W'(BYTES_N)) begin
      b = CFG_W'(BYTES_N);
    end
    return b;
  endfunction

  // Keep the low eff_bytes bytes
  function automatic logic [OCC_W-1:0] occ_mask(input logic [CFG_W-1:0] cfg);
    logic [OCC_W-1:0] m;
    logic [CFG_W-1:0] b;
    b = eff_bytes(cfg);
    for (int k = 0; k < BYTES_N; k++) begin
      m[8*k +: 8] = (CFG_W'(k) < b) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

[rtl/odc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odc_if: stream interfaces of the occurrence dedup counter
// Input channel carries occurrences, output channel carries distinct results.
// ----------------------------------------------------------------------------
interface odc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] occurrence;
  logic        group_end;

  modport source (output valid, output occurrence, output group_end, input ready);
  modport sink   (input valid, input occurrence, input group_end, output ready);
endinterface

interface odc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] distinct_value;
  logic [6:0]  repeat_count;
  logic [6:0]  distinct_total;
  logic [9:0]  group_bytes;
  logic        overflow;
  logic        last_result;

  modport source (output valid, output distinct_value, output repeat_count,
                  output distinct_total, output group_bytes, output overflow,
                  output last_result, input ready);
  modport sink   (input valid, input distinct_value, input repeat_count,
                  input distinct_total, input group_bytes, input overflow,
                  input last_result, output ready);
endinterface

[rtl/odc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odc_front: input stage of the occurrence dedup counter
// Accepts items while the queue has room and masks them to the byte count.
// ----------------------------------------------------------------------------
module odc_front (
  input  logic [odc_pkg::CFG_W-1:0] occurrence_bytes,
  odc_in_if.sink                    occ_in,
  input  logic                      q_full,
  output odc_pkg::queue_push_t      push
);
  import odc_pkg::*;

  // Accept while the queue has a free slot
  assign occ_in.ready = !q_full;

  // Mask and forward the item
  always_comb begin
    push.push           = occ_in.valid && !q_full;
    push.item.value     = occ_in.occurrence & occ_mask(occurrence_bytes);
    push.item.group_end = occ_in.group_end;
  end

endmodule

[rtl/odc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odc_queue: short item queue between front and back
// Two-entry FIFO so either side can stall without blocking the other.
// ----------------------------------------------------------------------------
module odc_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  odc_pkg::queue_push_t      push,
  input  logic                      pop,
  output logic                      q_full,
  output odc_pkg::queue_status_t    status
);
  import odc_pkg::*;

  occ_item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr;
  logic [Q_PTR_W-1:0]     rd_ptr;
  logic [Q_PTR_W:0]       fill;

  assign q_full           = (fill == (Q_PTR_W+1)'(Q_DEPTH));
  assign status.not_empty = (fill != '0);
  assign status.head      = slots[rd_ptr];

  // Write slot on push
  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/odc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odc_back: match, count and emit engine of the occurrence dedup counter
// Compares each item against all stored entries, updates counts or appends,
// and streams the distinct entries out after the group's last item.
// ----------------------------------------------------------------------------
module odc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [odc_pkg::CFG_W-1:0] occurrence_bytes,
  input  odc_pkg::queue_status_t    q_stat,
  output logic                      pop,
  odc_out_if.source                 result_out
);
  import odc_pkg::*;

  // Entry cells: each compared at its own place
  logic [OCC_W-1:0] value_store [MAX_OCC];
  logic [CNT_W-1:0] count_store [MAX_OCC];

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] distinct_fill;
  logic [CNT_W-1:0] stored_total;
  logic             dropped_flag;
  logic [IDX_W-1:0] emit_idx;

  logic [OCC_W-1:0] cur_value;
  logic             cur_end;
  logic [MAX_OCC-1:0] match_vec;
  logic [GB_W-1:0]  group_bytes;

  logic             out_valid;
  logic             any_match;
  logic             drop_now;
  logic [CNT_W-1:0] fill_upd;
  logic [CNT_W-1:0] total_upd;
  logic             emit_load;
  logic             emit_last;

  assign any_match = |match_vec;
  assign drop_now  = (stored_total >= CNT_W'(MAX_OCC));
  assign fill_upd  = distinct_fill + CNT_W'(!drop_now && !any_match);
  assign total_upd = stored_total + CNT_W'(!drop_now);
  assign emit_load = (state == B_EMIT) && (!out_valid || result_out.ready);
  assign emit_last = ((CNT_W'(emit_idx) + 1'b1) == distinct_fill);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_stat.not_empty) begin
          state_next = B_MATCH;
        end
      end
      B_MATCH: begin
        state_next = B_UPDATE;
      end
      B_UPDATE: begin
        if (cur_end) begin
          state_next = (fill_upd == '0) ? B_IDLE : B_EMIT;
        end else if (q_stat.not_empty) begin
          state_next = B_MATCH;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_EMIT: begin
        if (emit_load && emit_last) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Queue pop
  always_comb begin
    case (state)
      B_IDLE:   pop = q_stat.not_empty;
      B_UPDATE: pop = !cur_end && q_stat.not_empty;
      default:  pop = 1'b0;
    endcase
  end

  // Capture the popped item
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_value <= q_stat.head.value;
      cur_end   <= q_stat.head.group_end;
    end
  end

  // Compare against all filled entries
  always_ff @(posedge clk) begin
    if (state == B_MATCH) begin
      for (int i = 0; i < MAX_OCC; i++) begin
        match_vec[i] <= (CNT_W'(i) < distinct_fill) && (value_store[i] == cur_value);
      end
    end
  end

  // Bump the matching count or append a new entry
  always_ff @(posedge clk) begin
    if (state == B_UPDATE && !drop_now) begin
      for (int i = 0; i < MAX_OCC; i++) begin
        if (match_vec[i]) begin
          count_store[i] <= count_store[i] + 1'b1;
        end else if (!any_match && distinct_fill[IDX_W-1:0] == IDX_W'(i)) begin
          value_store[i] <= cur_value;
          count_store[i] <= CNT_W'(1);
        end
      end
    end
  end

  // Running group byte total, updated in every count/append state
  always_ff @(posedge clk) begin
    if (state == B_UPDATE) begin
      group_bytes <= GB_W'(eff_bytes(occurrence_bytes) * total_upd);
    end
  end

  // Group bookkeeping and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      distinct_fill <= '0;
      stored_total  <= '0;
      dropped_flag  <= 1'b0;
      emit_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_UPDATE) begin
        emit_idx <= '0;
        if (cur_end && fill_upd == '0) begin
          distinct_fill <= '0;
          stored_total  <= '0;
          dropped_flag  <= 1'b0;
        end else begin
          distinct_fill <= fill_upd;
          stored_total  <= total_upd;
          dropped_flag  <= dropped_flag | drop_now;
        end
      end
      if (emit_load) begin
        emit_idx <= emit_idx + 1'b1;
        if (emit_last) begin
          distinct_fill <= '0;
          stored_total  <= '0;
          dropped_flag  <= 1'b0;
        end
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      result_out.distinct_value <= value_store[emit_idx] & occ_mask(occurrence_bytes);
      result_out.repeat_count   <= count_store[emit_idx];
      result_out.distinct_total <= distinct_fill;
      result_out.group_bytes    <= group_bytes;
      result_out.overflow       <= dropped_flag;
      result_out.last_result    <= emit_last;
    end
  end

  assign result_out.valid = out_valid;

endmodule

[rtl/occurrence_dedup_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occurrence_dedup_counter_top: distinct occurrence counter, first-seen order
// Usage: occ_in carries one packed occurrence per item with group_end on the
// group's last item. cfg_wr_en/cfg_wr_data set the bytes per occurrence
// (0 acts as 1, above 8 acts as 8); write it only while the block is idle.
// After the last item, result_out streams one item per distinct occurrence in
// first-seen order with its repeat count, the distinct total, the group byte
// total, the overflow flag and last_result on the final entry.
// Each input item passes a compare state against all 64 stored entries and
// then a count/append state before the engine takes the next. A two-entry
// queue sits in front, so input is taken while the engine works.
// The group's last item passes the queue and the compare, count/append and
// emit states; results then follow one per cycle while ready is high.
// Reset: clears the group state and the queue; the byte count returns to 8.
// A stalled receiver holds the current result and pauses the emission; the
// queue takes up to two more items, then input waits until the group is
// drained. Up to 64 occurrences per group are kept; later ones are dropped
// and flagged.
// ----------------------------------------------------------------------------
module occurrence_dedup_counter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [odc_pkg::CFG_W-1:0] cfg_wr_data,
  odc_in_if.sink                    occ_in,
  odc_out_if.source                 result_out
);
  import odc_pkg::*;

  logic [CFG_W-1:0] occurrence_bytes;
  queue_push_t      push;
  queue_status_t    q_stat;
  logic             q_full;
  logic             pop;

  // Byte-count register
  always_ff @(posedge clk) begin
    if (rst) begin
      occurrence_bytes <= CFG_RESET;
    end else if (cfg_wr_en) begin
      occurrence_bytes <= cfg_wr_data;
    end
  end

  odc_front u_front (
    .occurrence_bytes (occurrence_bytes),
    .occ_in           (occ_in),
    .q_full           (q_full),
    .push             (push)
  );

  odc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .q_full (q_full),
    .status (q_stat)
  );

  odc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .occurrence_bytes (occurrence_bytes),
    .q_stat           (q_stat),
    .pop              (pop),
    .result_out       (result_out)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the occurrence dedup counter
// Drives groups of packed occurrences through the input stream, keeps an
// independent model of the distinct-entry store in first-seen order, and
// compares every emitted result field by field. Directed groups cover value
// extremes, byte-count clamping, a width change inside a group and the
// capacity limit. Random groups follow under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import odc_pkg::*;

  localparam int CLK_HALF_NS   = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 13;
  localparam int RANDOM_ITEMS  = 25;
  localparam longint RUN_LIMIT_NS = 400_000;

  typedef struct packed {
    logic [OCC_W-1:0] value;
    logic [CNT_W-1:0] repeats;
    logic [CNT_W-1:0] distinct;
    logic [GB_W-1:0]  bytes_total;
    logic             dropped;
    logic             final_entry;
  } dedup_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  odc_in_if  occ_if ();
  odc_out_if res_if ();

  occurrence_dedup_counter_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .occ_in     (occ_if.sink),
    .result_out (res_if.source)
  );

  // Model state of the current group
  logic [OCC_W-1:0] entry_value [MAX_OCC];
  logic [CNT_W-1:0] entry_count [MAX_OCC];
  int               entry_fill;
  int               occ_kept;
  bit               occ_dropped;
  logic [CFG_W-1:0] bytes_reg;

  dedup_result_t    pending_results [$];

  // Run statistics
  int  mismatches;
  int  results_checked;
  int  items_sent;
  int  groups_sent;
  int  overflow_groups;
  int  cfg_writes;
  bit  steady_stretch;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout at %0t", $time);
    $display("Mismatches found");
    $finish;
  end

  // Effective byte count: zero acts as one, above eight acts as eight
  function automatic int clamp_bytes(input logic [CFG_W-1:0] reg_val);
    int b;
    b = int'(reg_val);
    if (b < 1) begin
      b = 1;
    end else if (b > BYTES_N) begin
      b = BYTES_N;
    end
    return b;
  endfunction

  function automatic logic [OCC_W-1:0] keep_mask(input logic [CFG_W-1:0] reg_val);
    logic [OCC_W-1:0] m;
    m = '1;
    return m >> (OCC_W - 8 * clamp_bytes(reg_val));
  endfunction

  // Fold one accepted occurrence into the model; queue results on group end
  task automatic absorb_occurrence(input logic [OCC_W-1:0] raw, input logic closes);
    logic [OCC_W-1:0] masked;
    bit               hit;
    dedup_result_t    r;
    int               eff;
    masked = raw & keep_mask(bytes_reg);
    hit = 1'b0;
    if (occ_kept >= MAX_OCC) begin
      occ_dropped = 1'b1;
    end else begin
      for (int k = 0; k < entry_fill; k++) begin
        if (!hit && entry_value[k] == masked) begin
          entry_count[k] = entry_count[k] + 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit && entry_fill < MAX_OCC) begin
        entry_value[entry_fill] = masked;
        entry_count[entry_fill] = CNT_W'(1);
        entry_fill++;
      end
      occ_kept++;
    end
    if (closes) begin
      eff = clamp_bytes(bytes_reg);
      for (int k = 0; k < entry_fill; k++) begin
        r.value       = entry_value[k] & keep_mask(bytes_reg);
        r.repeats     = entry_count[k];
        r.distinct    = CNT_W'(entry_fill);
        r.bytes_total = GB_W'(eff * occ_kept);
        r.dropped     = occ_dropped;
        r.final_entry = (k == entry_fill - 1);
        pending_results = {pending_results, r};
      end
      if (occ_dropped) begin
        overflow_groups++;
      end
      groups_sent++;
      entry_fill  = 0;
      occ_kept    = 0;
      occ_dropped = 1'b0;
    end
  endtask

  // Offer one item, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_occurrence(input logic [OCC_W-1:0] v, input logic closes);
    @(negedge clk);
    while (!steady_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
      occ_if.valid <= 1'b0;
      @(negedge clk);
    end
    occ_if.valid      <= 1'b1;
    occ_if.occurrence <= v;
    occ_if.group_end  <= closes;
    do begin
      @(posedge clk);
    end while (occ_if.ready !== 1'b1);
    absorb_occurrence(v, closes);
    items_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the engine go quiet
  task automatic drain_block();
    @(negedge clk);
    occ_if.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bytes(input logic [CFG_W-1:0] b);
    drain_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    bytes_reg = b;
    cfg_writes++;
  endtask

  task automatic report_field(input string fld, input logic [OCC_W-1:0] want,
                              input logic [OCC_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
    end
  endtask

  // Receiver: stall at random, except during the steady stretch
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    dedup_result_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual value 0x%0h count %0d",
                 $time, res_if.distinct_value, res_if.repeat_count);
      end else begin
        want = pending_results.pop_front();
        report_field("distinct_value", want.value, res_if.distinct_value);
        report_field("repeat_count", OCC_W'(want.repeats), OCC_W'(res_if.repeat_count));
        report_field("distinct_total", OCC_W'(want.distinct), OCC_W'(res_if.distinct_total));
        report_field("group_bytes", OCC_W'(want.bytes_total), OCC_W'(res_if.group_bytes));
        report_field("overflow", OCC_W'(want.dropped), OCC_W'(res_if.overflow));
        report_field("last_result", OCC_W'(want.final_entry), OCC_W'(res_if.last_result));
      end
      results_checked++;
    end
  end

  // Value extremes and repeats at the reset width of eight bytes
  task automatic test_value_extremes();
    send_occurrence('0, 1'b0);
    send_occurrence('1, 1'b0);
    send_occurrence('0, 1'b0);
    send_occurrence({1'b1, 63'h0}, 1'b0);
    send_occurrence('1, 1'b1);
    // one-item group right behind the previous one
    send_occurrence(64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
  endtask

  // Register values zero and above eight clamp to one and eight bytes
  task automatic test_byte_clamp();
    write_bytes(CFG_W'(0));
    send_occurrence(64'hDEAD_BEEF_0000_1234, 1'b0);
    send_occurrence(64'h0000_0000_0000_FF34, 1'b0);
    send_occurrence(64'hFFFF_FFFF_FFFF_FF00, 1'b1);
    write_bytes(CFG_W'(15));
    send_occurrence(64'h8000_0000_0000_0001, 1'b0);
    send_occurrence(64'h0000_0000_0000_0001, 1'b1);
    write_bytes(CFG_W'(9));
    send_occurrence(64'h0123_4567_89AB_CDEF, 1'b1);
    write_bytes(CFG_W'(1));
    send_occurrence(64'h1111_1111_1111_11FF, 1'b0);
    send_occurrence(64'h0000_0000_0000_00FF, 1'b1);
  endtask

  // Width changed inside a group: stored entries keep their old mask
  task automatic test_width_change_in_group();
    write_bytes(CFG_W'(8));
    send_occurrence(64'h1111_2222_3333_4444, 1'b0);
    write_bytes(CFG_W'(2));
    send_occurrence(64'h9999_0000_8888_4444, 1'b0);
    send_occurrence(64'h0000_0000_0000_4444, 1'b1);
  endtask

  // Fill the store with 64 distinct entries, then repeats that must be dropped;
  // run it as one long stretch with no idling on either side
  task automatic test_capacity();
    write_bytes(CFG_W'(8));
    steady_stretch = 1'b1;
    for (int k = 0; k < MAX_OCC + 2; k++) begin
      send_occurrence({32'hC3C3_3C3C, 16'h0, 16'(k % MAX_OCC)}, k == MAX_OCC + 1);
    end
    drain_block();
    steady_stretch = 1'b0;
  endtask

  // Random groups with repeats, masked-off noise, width changes and stalls
  task automatic test_random_groups(input int item_goal);
    int               sent;
    int               len;
    logic [OCC_W-1:0] v;
    logic [OCC_W-1:0] seen [$];
    logic [CFG_W-1:0] b;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: b = CFG_W'(0);
          1: b = CFG_W'(1);
          2: b = CFG_W'(8);
          3: b = CFG_W'(15);
          default: b = CFG_W'($urandom_range(0, 15));
        endcase
        write_bytes(b);
      end else if ($urandom_range(0, 5) == 0) begin
        drain_block();
      end
      len = int'($urandom_range(1, 8));
      seen.delete();
      for (int k = 0; k < len; k++) begin
        if (seen.size() != 0 && $urandom_range(0, 1) == 1) begin
          // repeat an earlier value, maybe with changes above the kept bytes
          v = seen[$urandom_range(0, seen.size() - 1)];
          if ($urandom_range(0, 1) == 1) begin
            v = v ^ ({$urandom, $urandom} & ~keep_mask(bytes_reg));
          end
        end else begin
          v = {$urandom, $urandom};
        end
        seen = {seen, v};
        send_occurrence(v, k == len - 1);
      end
      sent += len;
    end
  endtask

  // Main sequence
  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    occ_if.valid      = 1'b0;
    occ_if.occurrence = '0;
    occ_if.group_end  = 1'b0;
    entry_fill        = 0;
    occ_kept          = 0;
    occ_dropped       = 1'b0;
    bytes_reg         = CFG_RESET;
    mismatches        = 0;
    results_checked   = 0;
    items_sent        = 0;
    groups_sent       = 0;
    overflow_groups   = 0;
    cfg_writes        = 0;
    steady_stretch    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_value_extremes();
    test_byte_clamp();
    test_width_change_in_group();
    test_capacity();
    test_random_groups(RANDOM_ITEMS);

    // Wait out the tail, then let any stray result show up
    drain_block();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d occurrences in %0d groups (%0d over capacity), %0d register writes.",
             items_sent, groups_sent, overflow_groups, cfg_writes);
    $display("Checked %0d distinct results, %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/odc_pkg.sv
rtl/odc_if.sv
rtl/odc_front.sv
rtl/odc_queue.sv
rtl/odc_back.sv
rtl/occurrence_dedup_counter_top.sv
verif/tb_top.sv
